// ----- sv/rrr_pkg.sv -----
// Package for the reliable receive reorder block.
// Holds field widths, result codes, FSM states, the result record and helpers.
// No dependencies; every other file of the block but rrr_ram imports it.
package rrr_pkg;

	localparam int unsigned CH_W  = 3;
	localparam int unsigned SEQ_W = 32;
	localparam int unsigned TAG_W = 16;
	localparam int unsigned CC_W  = 4;

	localparam int unsigned DEF_MAX_CHANNELS  = 8;
	localparam int unsigned DEF_REORDER_DEPTH = 16;
	localparam int unsigned DEF_DUP_WINDOW    = 64;

	localparam logic [CC_W-1:0]  CC_RESET   = CC_W'(8);
	localparam logic [SEQ_W-1:0] HALF_RANGE = 32'h7FFF_FFFF;
	localparam logic [SEQ_W-1:0] SEQ_MAX    = 32'hFFFF_FFFF;

	localparam logic [1:0] STAT_DELIVERED = 2'd0;
	localparam logic [1:0] STAT_QUEUED    = 2'd1;
	localparam logic [1:0] STAT_DUPLICATE = 2'd2;
	localparam logic [1:0] STAT_DROPPED   = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHAN,
		S_SLOT,
		S_DRAIN
	} fsm_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             ack;
		logic             msg_valid;
		logic [CH_W-1:0]  msg_channel;
		logic [SEQ_W-1:0] msg_sequence;
		logic [TAG_W-1:0] msg_tag;
		logic             last;
	} res_t;

	// Wrap-around "a is newer than b" over the 32-bit sequence space.
	function automatic logic seq_newer(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
		return ((a > b) && ((a - b) <= HALF_RANGE)) || ((a < b) && ((b - a) > HALF_RANGE));
	endfunction

	function automatic res_t mk_res(input logic [1:0] status, input logic ack,
		input logic valid, input logic [CH_W-1:0] ch, input logic [SEQ_W-1:0] seq,
		input logic [TAG_W-1:0] tag, input logic last);
		res_t r;
		r.status       = status;
		r.ack          = ack;
		r.msg_valid    = valid;
		r.msg_channel  = valid ? ch : '0;
		r.msg_sequence = valid ? seq : '0;
		r.msg_tag      = valid ? tag : '0;
		r.last         = last;
		return r;
	endfunction

endpackage

// ----- sv/rrr_if.sv -----
// Channel interfaces of the reliable receive reorder block: packets in, results out.
// Depends on rrr_pkg for the field widths.
interface rrr_pkt_if;
	import rrr_pkg::*;
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [CH_W-1:0]  channel;
	logic [SEQ_W-1:0] sequence_req;
	logic [TAG_W-1:0] payload_tag;
	modport source(output valid, req_type, channel, sequence_req, payload_tag, input ready);
	modport sink(input valid, req_type, channel, sequence_req, payload_tag, output ready);
endinterface

interface rrr_res_if;
	import rrr_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic             ack;
	logic             msg_valid;
	logic [CH_W-1:0]  msg_channel;
	logic [SEQ_W-1:0] msg_sequence;
	logic [TAG_W-1:0] msg_tag;
	logic             last;
	modport source(output valid, status, ack, msg_valid, msg_channel, msg_sequence, msg_tag,
		last, input ready);
	modport sink(input valid, status, ack, msg_valid, msg_channel, msg_sequence, msg_tag,
		last, output ready);
endinterface

// ----- sv/rrr_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module rrr_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16,
	parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- sv/reliable_receive_reorder_top.sv -----
// Top level of the reliable receive reorder block.
// Depends on rrr_pkg, the interfaces in rrr_if.sv and the generic RAM rrr_ram.
//
// This block sequences received packets per channel. Each packet transaction carries a
// channel, a 32-bit wrapping sequence number and a payload buffer tag. Duplicates are caught
// by a sliding bitmap of DUP_WINDOW bits below each channel's window high mark, and anything
// older than the window is a duplicate as well. A reliable packet that matches the expected
// sequence is delivered, followed by the stored packets that have become in order, one result
// transaction each, the final one flagged with last. A reliable packet up to REORDER_DEPTH-1
// ahead is stored in its slot and reported as queued (dropped if the slot holds another one);
// unsequenced packets are delivered at once. Per-channel state (expected sequence, high mark,
// bitmap) lives in one RAM and the slot sequence and tag in a second RAM, both with a
// registered read. The block works on one packet at a time. A packet that gives a single
// result goes through a channel RAM read and then the decision; a packet that is stored adds
// a slot RAM read; a delivery that drains stored messages adds one slot RAM read per drained
// message. The next packet is taken in the cycle after the final result enters the output
// register, and a stalled result consumer only holds the block when a further result must be
// loaded. channel_count may only be written while no packet is in flight.
module reliable_receive_reorder_top #(
	parameter int unsigned MAX_CHANNELS  = rrr_pkg::DEF_MAX_CHANNELS,
	parameter int unsigned REORDER_DEPTH = rrr_pkg::DEF_REORDER_DEPTH,
	parameter int unsigned DUP_WINDOW    = rrr_pkg::DEF_DUP_WINDOW
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rrr_pkg::CC_W-1:0]  cfg_wdata,
	rrr_pkt_if.sink                   pkt,
	rrr_res_if.source                 res
);
	import rrr_pkg::*;

	localparam int unsigned CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int unsigned MW    = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;
	localparam int unsigned MW1   = MW + 1;
	localparam int unsigned SLOTS = MAX_CHANNELS * REORDER_DEPTH;
	localparam int unsigned SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned BW    = $clog2(DUP_WINDOW);
	localparam int unsigned NW    = $clog2(REORDER_DEPTH + 1);
	localparam int unsigned SW    = SEQ_W + TAG_W;
	localparam logic [DUP_WINDOW-1:0] BIT_ONE = DUP_WINDOW'(1);

	// Per-channel word. The bitmap is kept relative to the high mark: bit j flags
	// sequence high-1-j, so advancing the mark is a left shift.
	typedef struct packed {
		logic [SEQ_W-1:0]      exp;
		logic [MW-1:0]         exp_mod;
		logic [SEQ_W-1:0]      high;
		logic [DUP_WINDOW-1:0] bits;
	} chan_t;

	localparam int unsigned CW = $bits(chan_t);

	function automatic logic [MW-1:0] nxt_mod(input logic [SEQ_W-1:0] e, input logic [MW-1:0] m);
		logic [MW-1:0] r;
		if (e == SEQ_MAX) begin
			r = '0;
		end else if (32'(m) == REORDER_DEPTH - 1) begin
			r = '0;
		end else begin
			r = m + MW'(1);
		end
		return r;
	endfunction

	function automatic logic [SAW-1:0] slot_addr(input logic [CH_W-1:0] c, input logic [MW-1:0] m);
		return SAW'(32'(c) * REORDER_DEPTH + 32'(m));
	endfunction

	// Registers.
	fsm_t              state_q, state_d;
	logic [CC_W-1:0]   cc_q;
	logic              type_q;
	logic [CH_W-1:0]   ch_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [TAG_W-1:0]  tag_q;
	logic [MAX_CHANNELS-1:0] chv_q;
	logic [SLOTS-1:0]  occ_q;
	chan_t             cur_q;
	logic [SAW-1:0]    idx_q;
	logic [NW-1:0]     n_q;
	res_t              pend_q;
	res_t              res_q;
	logic              rv_q;

	// RAM ports.
	logic              cmem_re, cmem_we;
	logic [CH_AW-1:0]  cmem_raddr, cmem_waddr;
	logic [CW-1:0]     cmem_rdata;
	chan_t             cmem_wdata;
	logic              smem_re, smem_we;
	logic [SAW-1:0]    smem_raddr;
	logic [SW-1:0]     smem_rdata, smem_wdata;

	// Datapath.
	chan_t             chan_rd;
	logic [8:0]        lim;
	logic              dec_drop, dec_dup, dec_unseq, dec_exp, dec_queue;
	logic [SEQ_W-1:0]  base, off, adv, seq_dist, mk_high;
	logic              older, ahead, in_range;
	logic [DUP_WINDOW-1:0] mk_bits;
	logic [MW-1:0]     qmod, m_next;
	logic [MW1-1:0]    qsum;
	logic [SEQ_W-1:0]  s_seq;
	logic [TAG_W-1:0]  s_tag;
	logic              slot_conflict, drain_match, out_free;

	// Control outputs of the FSM.
	logic              res_load, pend_load, cur_load, occ_set, occ_clr;
	res_t              res_d, pend_d;
	chan_t             cur_d;
	logic [SAW-1:0]    idx_d;
	logic [NW-1:0]     n_d;

	rrr_ram #(.Width(CW), .Depth(MAX_CHANNELS)) u_chan_ram (
		.clk   (clk),
		.we    (cmem_we),
		.waddr (cmem_waddr),
		.wdata (cmem_wdata),
		.re    (cmem_re),
		.raddr (cmem_raddr),
		.rdata (cmem_rdata)
	);

	rrr_ram #(.Width(SW), .Depth(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (smem_we),
		.waddr (idx_q),
		.wdata (smem_wdata),
		.re    (smem_re),
		.raddr (smem_raddr),
		.rdata (smem_rdata)
	);

	assign out_free   = !rv_q || res.ready;
	assign cmem_raddr = CH_AW'(pkt.channel);
	assign cmem_waddr = CH_AW'(ch_q);
	assign smem_wdata = {seq_q, tag_q};
	assign {s_seq, s_tag} = smem_rdata;

	// Decision on the channel word read for the current packet.
	always_comb begin
		chan_rd  = chv_q[CH_AW'(ch_q)] ? chan_t'(cmem_rdata) : '0;
		lim      = (32'(cc_q) > MAX_CHANNELS) ? 9'(MAX_CHANNELS) : 9'(cc_q);
		base     = chan_rd.high - SEQ_W'(DUP_WINDOW);
		older    = seq_newer(base, seq_q);
		ahead    = (seq_q == chan_rd.high) || seq_newer(seq_q, chan_rd.high);
		off      = chan_rd.high - SEQ_W'(1) - seq_q;
		adv      = seq_q + SEQ_W'(1) - chan_rd.high;
		if (ahead) begin
			mk_high = seq_q + SEQ_W'(1);
			mk_bits = (adv >= SEQ_W'(DUP_WINDOW)) ? BIT_ONE
				: ((chan_rd.bits << adv[BW-1:0]) | BIT_ONE);
		end else begin
			mk_high = chan_rd.high;
			mk_bits = chan_rd.bits | (BIT_ONE << off[BW-1:0]);
		end
		seq_dist = seq_q - chan_rd.exp;
		in_range = seq_newer(seq_q, chan_rd.exp) && (seq_dist < SEQ_W'(REORDER_DEPTH));
		// Slot of a packet ahead of expected: wrapped sequences are already below the depth.
		qsum = MW1'(chan_rd.exp_mod) + MW1'(seq_dist);
		if (seq_q < chan_rd.exp) begin
			qmod = MW'(seq_q);
		end else if (32'(qsum) >= REORDER_DEPTH) begin
			qmod = MW'(32'(qsum) - REORDER_DEPTH);
		end else begin
			qmod = MW'(qsum);
		end
		dec_drop  = (9'(ch_q) >= lim);
		dec_dup   = !dec_drop && (older || (!ahead && chan_rd.bits[off[BW-1:0]]));
		dec_unseq = !dec_drop && !dec_dup && type_q;
		dec_exp   = !dec_drop && !dec_dup && !type_q && (seq_q == chan_rd.exp);
		dec_queue = !dec_drop && !dec_dup && !type_q && (seq_q != chan_rd.exp) && in_range;
		m_next    = (state_q == S_DRAIN) ? nxt_mod(cur_q.exp, cur_q.exp_mod)
			: nxt_mod(chan_rd.exp, chan_rd.exp_mod);
		slot_conflict = occ_q[idx_q] && (s_seq != seq_q);
		drain_match   = occ_q[idx_q] && (s_seq == cur_q.exp) && (n_q < NW'(REORDER_DEPTH));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (pkt.valid) begin
					state_d = S_CHAN;
				end
			end
			S_CHAN: begin
				if (dec_exp) begin
					state_d = S_DRAIN;
				end else if (dec_queue) begin
					state_d = S_SLOT;
				end else if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_SLOT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_DRAIN: begin
				if (out_free && !drain_match) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// FSM outputs.
	always_comb begin
		pkt.ready  = 1'b0;
		cmem_re    = 1'b0;
		cmem_we    = 1'b0;
		cmem_wdata = cur_q;
		smem_re    = 1'b0;
		smem_we    = 1'b0;
		smem_raddr = idx_q;
		res_load   = 1'b0;
		res_d      = pend_q;
		pend_load  = 1'b0;
		pend_d     = pend_q;
		cur_load   = 1'b0;
		cur_d      = cur_q;
		idx_d      = idx_q;
		n_d        = n_q;
		occ_set    = 1'b0;
		occ_clr    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				pkt.ready = 1'b1;
				cmem_re   = pkt.valid;
			end
			S_CHAN: begin
				if (dec_exp) begin
					pend_load  = 1'b1;
					pend_d     = mk_res(STAT_DELIVERED, 1'b1, 1'b1, ch_q, seq_q, tag_q, 1'b0);
					cur_load   = 1'b1;
					cur_d      = '{exp: seq_q + SEQ_W'(1), exp_mod: m_next, high: mk_high,
						bits: mk_bits};
					smem_re    = 1'b1;
					smem_raddr = slot_addr(ch_q, m_next);
					idx_d      = smem_raddr;
					n_d        = '0;
				end else if (dec_queue) begin
					cur_load   = 1'b1;
					cur_d      = '{exp: chan_rd.exp, exp_mod: chan_rd.exp_mod, high: mk_high,
						bits: mk_bits};
					smem_re    = 1'b1;
					smem_raddr = slot_addr(ch_q, qmod);
					idx_d      = smem_raddr;
				end else if (out_free) begin
					res_load = 1'b1;
					if (dec_drop) begin
						res_d = mk_res(STAT_DROPPED, 1'b0, 1'b0, ch_q, seq_q, tag_q, 1'b1);
					end else if (dec_dup) begin
						res_d = mk_res(STAT_DUPLICATE, 1'b1, 1'b0, ch_q, seq_q, tag_q, 1'b1);
					end else if (dec_unseq) begin
						res_d      = mk_res(STAT_DELIVERED, 1'b1, 1'b1, ch_q, seq_q, tag_q, 1'b1);
						cmem_we    = 1'b1;
						cmem_wdata = '{exp: chan_rd.exp, exp_mod: chan_rd.exp_mod,
							high: mk_high, bits: mk_bits};
					end else begin
						// Reliable and behind expected, or too far ahead.
						res_d = mk_res(STAT_DROPPED, 1'b0, 1'b0, ch_q, seq_q, tag_q, 1'b1);
					end
				end
			end
			S_SLOT: begin
				if (out_free) begin
					res_load = 1'b1;
					if (slot_conflict) begin
						res_d = mk_res(STAT_DROPPED, 1'b0, 1'b0, ch_q, seq_q, tag_q, 1'b1);
					end else begin
						res_d   = mk_res(STAT_QUEUED, 1'b1, 1'b0, ch_q, seq_q, tag_q, 1'b1);
						smem_we = 1'b1;
						occ_set = 1'b1;
						cmem_we = 1'b1;
					end
				end
			end
			S_DRAIN: begin
				if (out_free) begin
					res_load   = 1'b1;
					res_d      = pend_q;
					res_d.last = !drain_match;
					if (drain_match) begin
						pend_load  = 1'b1;
						pend_d     = mk_res(STAT_DELIVERED, 1'b0, 1'b1, ch_q, cur_q.exp, s_tag,
							1'b0);
						occ_clr    = 1'b1;
						cur_load   = 1'b1;
						cur_d.exp     = cur_q.exp + SEQ_W'(1);
						cur_d.exp_mod = m_next;
						smem_re    = 1'b1;
						smem_raddr = slot_addr(ch_q, m_next);
						idx_d      = smem_raddr;
						n_d        = n_q + NW'(1);
					end else begin
						cmem_we = 1'b1;
					end
				end
			end
			default: begin
				pkt.ready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cc_q    <= CC_RESET;
			chv_q   <= '0;
			occ_q   <= '0;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cc_q <= cfg_wdata;
			end
			if (cmem_we) begin
				chv_q[cmem_waddr] <= 1'b1;
			end
			if (occ_set) begin
				occ_q[idx_q] <= 1'b1;
			end else if (occ_clr) begin
				occ_q[idx_q] <= 1'b0;
			end
			if (res_load) begin
				rv_q <= 1'b1;
			end else if (res.ready) begin
				rv_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			type_q <= pkt.req_type;
			ch_q   <= pkt.channel;
			seq_q  <= pkt.sequence_req;
			tag_q  <= pkt.payload_tag;
		end
		if (cur_load) begin
			cur_q <= cur_d;
		end
		idx_q <= idx_d;
		n_q   <= n_d;
		if (pend_load) begin
			pend_q <= pend_d;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res.valid        = rv_q;
	assign res.status       = res_q.status;
	assign res.ack          = res_q.ack;
	assign res.msg_valid    = res_q.msg_valid;
	assign res.msg_channel  = res_q.msg_channel;
	assign res.msg_sequence = res_q.msg_sequence;
	assign res.msg_tag      = res_q.msg_tag;
	assign res.last         = res_q.last;

	// A stored packet marks its slot as occupied.
	a_slot_occ: assert property (@(posedge clk) disable iff (!arst_n)
		smem_we |=> occ_q[$past(idx_q)])
		else $error("slot written but not marked occupied");

	// The drain never runs past the reorder depth.
	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> (n_q <= NW'(REORDER_DEPTH)))
		else $error("drain ran past the reorder depth");

	// A result without a message always closes its packet.
	a_nomsg_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && !res_d.msg_valid) |-> res_d.last)
		else $error("result without message not flagged last");

	// One packet at a time: no acceptance right after another.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt.valid && pkt.ready) |=> !pkt.ready)
		else $error("packet accepted while another is in flight");
endmodule

// ----- tb/rrr_tb_if.sv -----
`timescale 1ns / 100ps
// Testbench-side note: the channel interfaces rrr_pkt_if and rrr_res_if come from the RTL.
// This file holds the scoreboard class for the reliable receive reorder test.
// Depends on rrr_pkg for widths, status codes and the result record.
package rrr_tb_pkg;
	import rrr_pkg::*;

	class reorder_scoreboard;
		int unsigned      chan_limit;
		logic [SEQ_W-1:0] next_seq [8];
		logic [SEQ_W-1:0] high_mark [8];
		logic [63:0]      seen [8];
		bit               held [128];
		logic [SEQ_W-1:0] held_seq [128];
		logic [TAG_W-1:0] held_tag [128];
		res_t             pending [$];
		int unsigned      errors;

		function new();
			chan_limit = 8;
			errors = 0;
			foreach (next_seq[i]) begin
				next_seq[i] = '0;
				high_mark[i] = '0;
				seen[i] = '0;
			end
			foreach (held[i]) held[i] = 0;
		endfunction

		function void set_channels(logic [CC_W-1:0] v);
			chan_limit = (v > 8) ? 8 : v;
		endfunction

		function bit newer(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
			logic [SEQ_W-1:0] d1, d2;
			d1 = a - b;
			d2 = b - a;
			return ((a > b) && (d1 <= 32'h7FFF_FFFF)) || ((a < b) && (d2 > 32'h7FFF_FFFF));
		endfunction

		function bit is_dup(int ch, logic [SEQ_W-1:0] s);
			logic [SEQ_W-1:0] h;
			h = high_mark[ch];
			if (newer(h - 32'd64, s)) return 1;
			if (s == h || newer(s, h)) return 0;
			return seen[ch][s[5:0]];
		endfunction

		function void mark(int ch, logic [SEQ_W-1:0] s);
			logic [SEQ_W-1:0] h, adv;
			logic [SEQ_W-1:0] p;
			h = high_mark[ch];
			if (s == h || newer(s, h)) begin
				adv = s + 1 - h;
				if (adv >= 64) seen[ch] = '0;
				else for (int i = 0; i < adv; i++) begin
					p = h + i;
					seen[ch][p[5:0]] = 1'b0;
				end
				high_mark[ch] = s + 1;
			end
			seen[ch][s[5:0]] = 1'b1;
		endfunction

		function void push(logic [1:0] st, logic a, logic v, logic [CH_W-1:0] c,
			logic [SEQ_W-1:0] s, logic [TAG_W-1:0] t);
			res_t r;
			r.status = st; r.ack = a; r.msg_valid = v;
			r.msg_channel = v ? c : '0;
			r.msg_sequence = v ? s : '0;
			r.msg_tag = v ? t : '0;
			r.last = 1'b0;
			pending.insert(pending.size(), r);
		endfunction

		// Note one accepted packet and queue the results it should cause.
		function void note_packet(logic kind, logic [CH_W-1:0] ch, logic [SEQ_W-1:0] s,
			logic [TAG_W-1:0] t);
			int idx;
			logic [SEQ_W-1:0] e, gap;
			if (ch >= chan_limit) push(STAT_DROPPED, 0, 0, 0, 0, 0);
			else if (is_dup(ch, s)) push(STAT_DUPLICATE, 1, 0, 0, 0, 0);
			else if (kind) begin
				mark(ch, s);
				push(STAT_DELIVERED, 1, 1, ch, s, t);
			end else if (s == next_seq[ch]) begin
				mark(ch, s);
				push(STAT_DELIVERED, 1, 1, ch, s, t);
				next_seq[ch] = s + 1;
				for (int n = 0; n < 16; n++) begin
					e = next_seq[ch];
					idx = ch * 16 + e[3:0];
					if (!held[idx] || held_seq[idx] != e) break;
					push(STAT_DELIVERED, 0, 1, ch, e, held_tag[idx]);
					held[idx] = 0;
					next_seq[ch] = e + 1;
				end
			end else begin
				gap = s - next_seq[ch];
				idx = ch * 16 + s[3:0];
				if (!newer(s, next_seq[ch]) || gap >= 16) push(STAT_DROPPED, 0, 0, 0, 0, 0);
				else if (held[idx] && held_seq[idx] != s) push(STAT_DROPPED, 0, 0, 0, 0, 0);
				else begin
					mark(ch, s);
					held[idx] = 1; held_seq[idx] = s; held_tag[idx] = t;
					push(STAT_QUEUED, 1, 0, 0, 0, 0);
				end
			end
			pending[$].last = 1'b1;
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: result mismatch expected %h actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass
endpackage

// ----- tb/reliable_receive_reorder_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking test of reliable_receive_reorder_top with directed and random packets.
// Depends on rrr_pkg, the RTL channel interfaces and the scoreboard in rrr_tb_pkg.
module reliable_receive_reorder_top_test;
	import rrr_pkg::*;
	import rrr_tb_pkg::*;

	localparam int unsigned STALL_LIMIT = 5000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b1;
	logic             cfg_we = 1'b0;
	logic [CC_W-1:0]  cfg_wdata = '0;
	bit               calm = 0;
	int unsigned      idle_cycles = 0;

	rrr_pkt_if pkt ();
	rrr_res_if res ();

	reliable_receive_reorder_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.pkt(pkt), .res(res)
	);

	reorder_scoreboard board = new();

	always #10 clk = ~clk;

	initial begin
		pkt.valid = 1'b0;
		pkt.req_type = 1'b0;
		pkt.channel = '0;
		pkt.sequence_req = '0;
		pkt.payload_tag = '0;
		res.ready = 1'b0;
	end

	// The result side drops ready at random, with a probability of 23 percent, except during calm stretches.
	// Every accepted result transaction is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res.valid && res.ready)
				board.check_result({res.status, res.ack, res.msg_valid, res.msg_channel,
					res.msg_sequence, res.msg_tag, res.last});
			res.ready <= calm || ($urandom_range(99) >= 23);
		end
	end

	// Watchdog: count cycles in which no transaction moves on either channel.
	always @(posedge clk) begin
		if ((pkt.valid && pkt.ready) || (res.valid && res.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Offer one packet and hold it until the block takes it; the scoreboard is told at the
	// accepting edge so that its state follows the block packet by packet. Valid stays high
	// after acceptance until the next packet or a pause replaces it; the block is busy then.
	task automatic send_packet(logic kind, logic [CH_W-1:0] ch, logic [SEQ_W-1:0] s,
		logic [TAG_W-1:0] t);
		while (!calm && $urandom_range(99) < 23) begin
			pkt.valid <= 1'b0;
			@(posedge clk);
		end
		pkt.valid <= 1'b1;
		pkt.req_type <= kind;
		pkt.channel <= ch;
		pkt.sequence_req <= s;
		pkt.payload_tag <= t;
		do @(posedge clk); while (!pkt.ready);
		board.note_packet(kind, ch, s, t);
	endtask

	// Let all expected results arrive, then allow a margin for drain work still in flight.
	task automatic settle();
		pkt.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Register writes happen only while the block is idle.
	task automatic write_channels(logic [CC_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_channels(v);
	endtask

	// A well-formed burst on one channel: sequences near the expected one, shuffled so
	// that some are stored and later drained, with occasional repeats and far jumps.
	task automatic random_burst(int ch, output int count);
		logic [SEQ_W-1:0] start;
		int n, order[$];
		start = board.next_seq[ch];
		n = $urandom_range(1, 12);
		count = n;
		for (int i = 0; i < n; i++) order.push_back(i);
		order.shuffle();
		foreach (order[i]) begin
			case ($urandom_range(9))
				0: send_packet(1'b1, CH_W'(ch), start + $urandom_range(80), TAG_W'($urandom));
				1: send_packet(1'b0, CH_W'(ch), start - $urandom_range(1, 70), TAG_W'($urandom));
				2: send_packet(1'b0, CH_W'(ch), $urandom, TAG_W'($urandom));
				default: send_packet(1'b0, CH_W'(ch), start + order[i], TAG_W'($urandom));
			endcase
		end
	endtask

	initial begin
		int sent;
		int burst_len;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		calm = 1;

		// Directed part: in-order delivery, a stored run drained at once, duplicates, packets too far
		// ahead, unsequenced packets and field extremes.
		for (int i = 16; i >= 1; i--) send_packet(1'b0, 0, SEQ_W'(i), TAG_W'(16'hFFFF - i));
		send_packet(1'b0, 0, 0, 16'h0000);           // delivers 0 and drains 15 stored
		send_packet(1'b0, 0, 5, 16'h1234);           // duplicate inside the window
		send_packet(1'b0, 0, 40, 16'h1);             // too far ahead
		send_packet(1'b1, 0, 32'hFFFF_FFFF, 16'hFFFF); // unsequenced, inside the window: delivered
		send_packet(1'b1, 1, 100, 16'hABCD);         // unsequenced moves the high mark
		send_packet(1'b0, 1, 40, 16'h2);             // ahead of expected but too far, not duplicate
		send_packet(1'b0, 1, 3, 16'h3);              // at/below window base: duplicate
		send_packet(1'b0, 7, 32'h8000_0000, 16'h4);  // behind by half the range
		send_packet(1'b0, 2, 2, 16'h5);              // stored
		send_packet(1'b0, 2, 2, 16'h6);              // duplicate of stored
		send_packet(1'b1, 2, 101, 16'h7);            // high mark jumps, bitmap clears
		send_packet(1'b0, 2, 18, 16'h8);             // slot 2 taken, but 18 is below the window base: duplicate

		write_channels(1);
		send_packet(1'b0, 3, 0, 16'h9);              // invalid channel is dropped
		send_packet(1'b0, 0, 17, 16'hA);
		write_channels(0);
		send_packet(1'b0, 0, 18, 16'hB);
		write_channels(15);                          // above the maximum acts as 8
		send_packet(1'b0, 7, 0, 16'hC);
		calm = 0;

		// Random part: mostly bursts around the expected sequence on each channel.
		sent = 0;
		while (sent < 310) begin
			if (sent > 100 && sent < 160) calm = 1;
			else calm = 0;
			if ($urandom_range(40) == 0)
				write_channels(CC_W'($urandom_range(15)));
			if ($urandom_range(9) == 0) begin
				send_packet(1'($urandom), CH_W'($urandom), $urandom, TAG_W'($urandom));
				sent++;
			end else begin
				random_burst($urandom_range(7), burst_len);
				sent += burst_len;
			end
		end
		calm = 0;

		settle();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
